// ----- rtl/core/pps_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; every module of the block imports this package.
package pps_pkg;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int TIME_W  = 16;
    localparam int PRIO_W  = 8;
    localparam int CLOCK_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    // One process slot as it is kept in the slot table.
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [PRIO_W-1:0] prio;
    } t_entry;

endpackage

// ----- rtl/core/pps_pick_unit.sv -----
// Shared comparator that keeps the best ready candidate seen during a table scan.
// Depends on pps_pkg for the slot entry type.
module pps_pick_unit
    import pps_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start_scan,
    input  logic             i_cand_v,
    input  logic             i_cand_ready,
    input  logic [IDX_W-1:0] i_cand_idx,
    input  t_entry           i_cand,
    output logic             o_found,
    output logic [IDX_W-1:0] o_best_idx,
    output t_entry           o_best
);

    logic             r_found;
    logic [IDX_W-1:0] r_best_idx;
    t_entry           r_best;
    logic             beats;
    logic             take;

    // Higher priority wins; equal priority goes to the earlier arrival.
    // A full tie keeps the earlier (lower) slot because the scan ascends.
    always_comb begin
        beats = (i_cand.prio > r_best.prio) ||
                ((i_cand.prio == r_best.prio) && (i_cand.arrival < r_best.arrival));
        take  = i_cand_v && i_cand_ready && (!r_found || beats);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_start_scan) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_idx <= i_cand_idx;
            r_best     <= i_cand;
        end
    end

    assign o_found    = r_found;
    assign o_best_idx = r_best_idx;
    assign o_best     = r_best;

endmodule

// ----- rtl/core/preemptive_priority_scheduler.sv -----
// Top level of the preemptive priority scheduler: command decode, slot table,
// scan sequencer and result registers. Depends on pps_pkg and pps_pick_unit.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  --------------------------------------------
//  command   i_start high, o_busy low  i_cmd, i_slot, i_arrival, i_burst,
//                                      i_priority_req
//  result    o_res_strobe, one cycle   o_busy_res, o_running_slot, o_finished,
//                                      o_finish_time, o_turnaround, o_waiting,
//                                      o_all_done, o_clock_now
//
// Load, clear and unused command beats complete at the edge that accepts them and
// never raise o_busy. A tick beat holds o_busy through the scan and the states after
// it: the slot table is a single-port memory, so the scan reads one slot per cycle
// into one shared comparator, then passes through a drain, an update and a result
// state. The result strobe rises in the same cycle that o_busy drops. The receiver
// cannot stall; each result beat is shown for exactly one cycle. Reset is
// synchronous and active low; it clears the live bits, the clock and the
// sequencer, and the table contents are left as they are since every read of
// them is gated by a live bit.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [TIME_W-1:0]   i_arrival,
    input  logic [TIME_W-1:0]   i_burst,
    input  logic [PRIO_W-1:0]   i_priority_req,
    output logic                o_res_strobe,
    output logic                o_busy_res,
    output logic [SLOT_W-1:0]   o_running_slot,
    output logic                o_finished,
    output logic [CLOCK_W-1:0]  o_finish_time,
    output logic [CLOCK_W-1:0]  o_turnaround,
    output logic [CLOCK_W-1:0]  o_waiting,
    output logic                o_all_done,
    output logic [CLOCK_W-1:0]  o_clock_now
);

    localparam int IW = $clog2(SLOTS);

    // Slot table. Entries are only meaningful where the matching live bit or a
    // previous load says so, hence no reset on the array.
    t_entry r_mem [SLOTS];

    // A slot is live when it is loaded and still has time left. This covers both
    // the ready test of the scan and the all-done flag.
    logic [SLOTS-1:0] r_live, n_live;
    logic [CLOCK_W-1:0] r_clock, n_clock;

    t_state r_state, n_state;
    logic [IW-1:0] r_addr, n_addr;
    logic          r_rd_v, n_rd_v;
    logic [IW-1:0] r_rd_idx;
    t_entry        r_rd_data;

    logic accept;
    t_cmd cmd;
    logic [IW+SLOT_W-1:0] slot_ext;
    logic                 slot_ok;
    logic [IW-1:0]        load_idx;

    logic          start_scan;
    logic          cand_ready;
    logic          found;
    logic [IW-1:0] best_idx;
    t_entry        best;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;

    logic [TIME_W-1:0] rem_dec;

    // Values carried from the update cycle to the result cycle.
    logic                r_found, r_done;
    logic [IW-1:0]       r_pick;
    logic [CLOCK_W-1:0]  r_tat;
    logic [TIME_W-1:0]   r_burst;

    logic [IW+SLOT_W-1:0] pick_ext;

    assign accept   = i_start && !o_busy;
    assign cmd      = t_cmd'(i_cmd);
    assign slot_ext = {{IW{1'b0}}, i_slot};
    assign slot_ok  = (32'(i_slot) < 32'(SLOTS));
    assign load_idx = slot_ext[IW-1:0];
    assign o_busy   = (r_state != ST_IDLE);
    assign rem_dec  = best.remaining - TIME_W'(1);

    // Sequencer: next state, scan address and the live-bit / clock updates.
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_rd_v     = 1'b0;
        n_live     = r_live;
        n_clock    = r_clock;
        start_scan = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = load_idx;
        mem_wdata  = '{arrival: i_arrival, burst: i_burst,
                       remaining: i_burst, prio: i_priority_req};
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_LOAD: begin
                            if (slot_ok) begin
                                mem_we           = 1'b1;
                                n_live[load_idx] = (i_burst != '0);
                            end
                        end
                        CMD_TICK: begin
                            start_scan = 1'b1;
                            n_addr     = '0;
                            n_state    = ST_SCAN;
                        end
                        CMD_CLEAR: begin
                            n_live  = '0;
                            n_clock = '0;
                        end
                        CMD_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_rd_v = 1'b1;
                n_addr = r_addr + IW'(1);
                if (r_addr == IW'(SLOTS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last slot read is compared in this cycle.
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (r_clock != '1) begin
                    n_clock = r_clock + CLOCK_W'(1);
                end
                if (found) begin
                    mem_we    = 1'b1;
                    mem_waddr = best_idx;
                    mem_wdata = '{arrival: best.arrival, burst: best.burst,
                                  remaining: rem_dec, prio: best.prio};
                    n_live[best_idx] = (rem_dec != '0);
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd_v  <= 1'b0;
            r_live  <= '0;
            r_clock <= '0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= n_rd_v;
            r_live  <= n_live;
            r_clock <= n_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    // Single-port table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
        r_rd_idx  <= r_addr;
    end

    // A slot is ready when it is live and has arrived by the current clock.
    assign cand_ready = r_live[r_rd_idx] &&
                        ({{(CLOCK_W-TIME_W){1'b0}}, r_rd_data.arrival} <= r_clock);

    pps_pick_unit #(
        .IDX_W (IW)
    ) u_pick (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_scan (start_scan),
        .i_cand_v     (r_rd_v),
        .i_cand_ready (cand_ready),
        .i_cand_idx   (r_rd_idx),
        .i_cand       (r_rd_data),
        .o_found      (found),
        .o_best_idx   (best_idx),
        .o_best       (best)
    );

    // Update cycle: the turnaround subtract is done here against the advanced
    // clock; the waiting subtract follows in the result cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_found <= found;
            r_pick  <= best_idx;
            r_done  <= found && (rem_dec == '0);
            r_tat   <= n_clock - {{(CLOCK_W-TIME_W){1'b0}}, best.arrival};
            r_burst <= best.burst;
        end
    end

    assign pick_ext = {{SLOT_W{1'b0}}, r_pick};

    // Result registers. Waiting floors at zero, which only matters once the
    // clock has saturated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_strobe <= 1'b0;
        end else begin
            o_res_strobe <= (r_state == ST_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH) begin
            o_busy_res     <= r_found;
            o_running_slot <= r_found ? pick_ext[SLOT_W-1:0] : '0;
            o_finished     <= r_done;
            o_finish_time  <= r_done ? r_clock : '0;
            o_turnaround   <= r_done ? r_tat : '0;
            if (r_done && (r_tat >= {{(CLOCK_W-TIME_W){1'b0}}, r_burst})) begin
                o_waiting <= r_tat - {{(CLOCK_W-TIME_W){1'b0}}, r_burst};
            end else begin
                o_waiting <= '0;
            end
            o_all_done     <= ~|r_live;
            o_clock_now    <= r_clock;
        end
    end

endmodule
